[sv/pwd_pkg.sv]
package pwd_pkg;

    // Command codes
    localparam logic CMD_SEGMENT = 1'b0;
    localparam logic CMD_BYTE    = 1'b1;

    // Decoder phase codes
    localparam logic [2:0] PH_TAG     = 3'd0;
    localparam logic [2:0] PH_DATA    = 3'd1;
    localparam logic [2:0] PH_ZCOUNT  = 3'd2;
    localparam logic [2:0] PH_LCOUNT  = 3'd3;
    localparam logic [2:0] PH_LITERAL = 3'd4;

    // Result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [1:0] STATUS_NO_SEG   = 2'd2;

    localparam logic [7:0] ALL_NONZERO_TAG = 8'hff;
    localparam logic [3:0] WORD_BYTES      = 4'd8;

    typedef struct packed {
        logic [63:0] word_data;
        logic [8:0]  repeat_count;
        logic        segment_end;
        logic [1:0]  status;
    } t_result;

    // Lowest set tag bit at or above position from; WORD_BYTES if none
    function automatic logic [3:0] next_set(input logic [7:0] tag, input logic [3:0] from);
        logic [3:0] pos;
        pos = WORD_BYTES;
        for (int i = 7; i >= 0; i--) begin
            if (tag[i] && (4'(i) >= from)) begin
                pos = 4'(i);
            end
        end
        return pos;
    endfunction

endpackage

[sv/pwd_core.sv]
module pwd_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic             i_cmd,
    input  logic [19:0]      i_segment_words,
    input  logic [7:0]       i_packed_byte,
    output logic             o_res_valid,
    output pwd_pkg::t_result o_res
);

    logic [2:0]  r_phase,       n_phase;
    logic [7:0]  r_tag,         n_tag;
    logic [3:0]  r_cursor,      n_cursor;
    logic [63:0] r_word,        n_word;
    logic [19:0] r_words_left,  n_words_left;
    logic [7:0]  r_lit_left,    n_lit_left;
    logic [2:0]  r_lit_idx,     n_lit_idx;

    logic [63:0] data_merged;
    logic [63:0] lit_merged;
    logic [3:0]  cursor_next;
    logic [19:0] words_m1;
    logic [7:0]  lit_left_m1;
    logic [8:0]  run_len;
    logic [19:0] words_after_run;

    // Byte placement and helper values
    always_comb begin
        data_merged     = r_word | ({56'd0, i_packed_byte} << {r_cursor[2:0], 3'b000});
        lit_merged      = r_word | ({56'd0, i_packed_byte} << {r_lit_idx, 3'b000});
        cursor_next     = pwd_pkg::next_set(r_tag, {1'b0, r_cursor[2:0]} + 4'd1);
        words_m1        = r_words_left - 20'd1;
        lit_left_m1     = r_lit_left - 8'd1;
        run_len         = 9'd1 + {1'b0, i_packed_byte};
        words_after_run = r_words_left - 20'(run_len);
    end

    // Per-transaction decode
    always_comb begin
        n_phase      = r_phase;
        n_tag        = r_tag;
        n_cursor     = r_cursor;
        n_word       = r_word;
        n_words_left = r_words_left;
        n_lit_left   = r_lit_left;
        n_lit_idx    = r_lit_idx;
        o_res_valid  = 1'b0;
        o_res        = '0;

        if (i_fire) begin
            if (i_cmd == pwd_pkg::CMD_SEGMENT) begin
                n_phase      = pwd_pkg::PH_TAG;
                n_tag        = '0;
                n_cursor     = '0;
                n_word       = '0;
                n_words_left = i_segment_words;
                n_lit_left   = '0;
                n_lit_idx    = '0;
            end else begin
                unique case (r_phase) inside
                    pwd_pkg::PH_DATA: begin
                        n_cursor = cursor_next;
                        if (cursor_next == pwd_pkg::WORD_BYTES) begin
                            if (r_tag == pwd_pkg::ALL_NONZERO_TAG) begin
                                n_phase = pwd_pkg::PH_LCOUNT;
                                n_word  = data_merged;
                            end else begin
                                n_words_left       = words_m1;
                                n_phase            = pwd_pkg::PH_TAG;
                                n_word             = '0;
                                o_res_valid        = 1'b1;
                                o_res.word_data    = data_merged;
                                o_res.repeat_count = 9'd1;
                                o_res.segment_end  = (words_m1 == 20'd0);
                                o_res.status       = pwd_pkg::STATUS_OK;
                            end
                        end else begin
                            n_word = data_merged;
                        end
                    end
                    pwd_pkg::PH_ZCOUNT, pwd_pkg::PH_LCOUNT: begin
                        o_res_valid = 1'b1;
                        if ({12'd0, i_packed_byte} > words_m1) begin
                            // run passes the segment end: abort
                            n_phase           = pwd_pkg::PH_TAG;
                            n_tag             = '0;
                            n_cursor          = '0;
                            n_word            = '0;
                            n_words_left      = '0;
                            n_lit_left        = '0;
                            n_lit_idx         = '0;
                            o_res.segment_end = 1'b1;
                            o_res.status      = pwd_pkg::STATUS_OVERFLOW;
                        end else if (r_phase == pwd_pkg::PH_ZCOUNT) begin
                            n_words_left       = words_after_run;
                            n_phase            = pwd_pkg::PH_TAG;
                            o_res.repeat_count = run_len;
                            o_res.segment_end  = (words_after_run == 20'd0);
                            o_res.status       = pwd_pkg::STATUS_OK;
                        end else begin
                            n_words_left       = words_m1;
                            o_res.word_data    = r_word;
                            o_res.repeat_count = 9'd1;
                            o_res.segment_end  = (words_m1 == 20'd0);
                            o_res.status       = pwd_pkg::STATUS_OK;
                            n_word             = '0;
                            if (i_packed_byte == 8'd0) begin
                                n_phase = pwd_pkg::PH_TAG;
                            end else begin
                                n_phase    = pwd_pkg::PH_LITERAL;
                                n_lit_left = i_packed_byte;
                                n_lit_idx  = '0;
                            end
                        end
                    end
                    pwd_pkg::PH_LITERAL: begin
                        if (r_lit_idx != 3'd7) begin
                            n_lit_idx = r_lit_idx + 3'd1;
                            n_word    = lit_merged;
                        end else begin
                            n_lit_idx          = '0;
                            n_words_left       = words_m1;
                            n_lit_left         = lit_left_m1;
                            n_word             = '0;
                            o_res_valid        = 1'b1;
                            o_res.word_data    = lit_merged;
                            o_res.repeat_count = 9'd1;
                            o_res.segment_end  = (words_m1 == 20'd0);
                            o_res.status       = pwd_pkg::STATUS_OK;
                            if (lit_left_m1 == 8'd0) begin
                                n_phase = pwd_pkg::PH_TAG;
                            end
                        end
                    end
                    default: begin
                        // tag byte
                        if (r_words_left == 20'd0) begin
                            o_res_valid  = 1'b1;
                            o_res.status = pwd_pkg::STATUS_NO_SEG;
                        end else begin
                            n_tag  = i_packed_byte;
                            n_word = '0;
                            if (i_packed_byte == 8'd0) begin
                                n_cursor = '0;
                                n_phase  = pwd_pkg::PH_ZCOUNT;
                            end else begin
                                n_cursor = pwd_pkg::next_set(i_packed_byte, 4'd0);
                                n_phase  = pwd_pkg::PH_DATA;
                            end
                        end
                    end
                endcase
            end
        end
    end

    // Decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= pwd_pkg::PH_TAG;
            r_tag        <= '0;
            r_cursor     <= '0;
            r_word       <= '0;
            r_words_left <= '0;
            r_lit_left   <= '0;
            r_lit_idx    <= '0;
        end else begin
            r_phase      <= n_phase;
            r_tag        <= n_tag;
            r_cursor     <= n_cursor;
            r_word       <= n_word;
            r_words_left <= n_words_left;
            r_lit_left   <= n_lit_left;
            r_lit_idx    <= n_lit_idx;
        end
    end

    // A segment start leaves the decoder waiting for a tag with the new length
    a_seg_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_cmd == pwd_pkg::CMD_SEGMENT) |=>
            (r_phase == pwd_pkg::PH_TAG && r_words_left == $past(i_segment_words)))
        else $error("segment start did not load decoder state");

    // Mid-word phases only exist inside an open segment
    a_open_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != pwd_pkg::PH_TAG) |-> (r_words_left != 20'd0))
        else $error("decoding a word with no segment open");

    // Literal phase always has at least one literal word pending
    a_lit_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == pwd_pkg::PH_LITERAL) |-> (r_lit_left != 8'd0))
        else $error("literal phase with no literal words left");

    // Good results always stand for at least one word
    a_ok_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status == pwd_pkg::STATUS_OK) |-> (o_res.repeat_count != 9'd0))
        else $error("ok result with zero repeat count");

endmodule

[sv/packed_word_decoder_top.sv]
// Packed zero-byte word decoder.
// Input channel (i_valid / o_ready): one transaction per command. i_cmd 0 opens
// a segment of i_segment_words words; i_cmd 1 delivers one packed byte.
// Output channel (o_valid / i_ready): decoded words, each with a repeat count,
// a segment-end flag and a status (ok, run overflow, byte outside a segment).
// Segment starts and most bytes produce no result; a result comes with the
// last byte of a word, the count byte after a tag of 0 or 0xff, or a tag
// byte outside a segment. Throughput: one transaction per cycle, sustained
// while the skid entry is free. Each byte is registered, decoded against the
// decoder state combinationally and written to the result register or skid.
// A second result register (skid) lets one more transaction be decoded while
// a result waits; o_ready is decoded from register state only and drops only
// when the skid entry and the input register are both full.
// Reset (i_rst_n low, synchronous) empties the pipeline and returns the
// decoder to "no segment open", waiting for a tag byte.
module packed_word_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_cmd,
    input  logic [19:0] i_segment_words,
    input  logic [7:0]  i_packed_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_word_data,
    output logic [8:0]  o_repeat_count,
    output logic        o_segment_end,
    output logic [1:0]  o_status
);

    logic             r_in_valid;
    logic             r_in_cmd;
    logic [19:0]      r_in_seg;
    logic [7:0]       r_in_byte;
    logic             r_out_valid;
    pwd_pkg::t_result r_out;
    logic             r_skid_valid;
    pwd_pkg::t_result r_skid;

    logic             dec_fire;
    logic             res_valid;
    pwd_pkg::t_result res;
    logic             out_pop;

    assign dec_fire = r_in_valid && !r_skid_valid;
    assign o_ready  = !r_in_valid || dec_fire;
    assign out_pop  = r_out_valid && i_ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_cmd  <= i_cmd;
            r_in_seg  <= i_segment_words;
            r_in_byte <= i_packed_byte;
        end
    end

    pwd_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (dec_fire),
        .i_cmd           (r_in_cmd),
        .i_segment_words (r_in_seg),
        .i_packed_byte   (r_in_byte),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    // Result register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= res_valid;
            end
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_pop) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else begin
                r_out <= res;
            end
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_word_data    = r_out.word_data;
    assign o_repeat_count = r_out.repeat_count;
    assign o_segment_end  = r_out.segment_end;
    assign o_status       = r_out.status;

    // Skid entry is only used behind a held result
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry filled while result register empty");

    // A decoded result never lands while both result entries are full
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_skid_valid) |-> !dec_fire)
        else $error("decode while result buffer full");

    // Overflow results always close the segment
    a_overflow_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == pwd_pkg::STATUS_OVERFLOW) |-> o_segment_end)
        else $error("overflow result without segment end");

endmodule
